// ===== src/fqr_pkg.sv =====
// Shared types and constants for the queue with remove-by-value.
// Used by fqr_cell and by the top level fifo_queue_with_remove.
package fqr_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int DEPTH_DEF = 16;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_POP,
        CMD_MARK,
        CMD_SQUEEZE
    } t_cell_cmd;

    // What one cell shows to its neighbor.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } t_link;

endpackage

// ===== src/fqr_cell.sv =====
// One storage cell of the queue chain: an entry and its valid bit.
// Depends on fqr_pkg for the command and link types.
module fqr_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fqr_pkg::t_cell_cmd        i_cmd,
    input  logic [fqr_pkg::DATA_W-1:0] i_key,
    input  logic                      i_below_valid,
    input  fqr_pkg::t_link            i_above,
    output fqr_pkg::t_link            o_link,
    output logic                      o_match,
    output logic                      o_hole
);
    import fqr_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic              n_valid;
    logic [DATA_W-1:0] n_data;

    assign o_match = r_valid && (r_data == i_key);
    assign o_hole  = !r_valid && i_above.valid;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_cmd)
            CMD_PUSH: begin
                // The first free cell above the last held entry takes the value.
                if (!r_valid && i_below_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_key;
                end
            end
            CMD_POP: begin
                n_valid = i_above.valid;
                n_data  = i_above.data;
            end
            CMD_MARK: begin
                if (o_match) begin
                    n_valid = 1'b0;
                end
            end
            CMD_SQUEEZE: begin
                // Entries step down one cell into a hole below them.
                if (o_hole) begin
                    n_valid = 1'b1;
                    n_data  = i_above.data;
                end else if (r_valid && !i_below_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_valid = r_valid;
                n_data  = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_link.valid = r_valid;
    assign o_link.data  = r_data;

endmodule

// ===== src/fifo_queue_with_remove.sv =====
// Top level of the first-in first-out queue with remove-by-value.
// Depends on fqr_pkg and instantiates a chain of fqr_cell.
//
// Usage: a transaction is offered by raising start with i_op and i_value_in;
// it is taken at a rising edge where start is high and busy is low. Every
// transaction gives exactly one result, shown for one cycle with o_valid high:
// o_ok, o_value_out, o_count, o_empty_res and o_full_res.
// The queue is a row of DEPTH cells; cell 0 always holds the oldest entry and
// held entries always fill a prefix of the row when the block is idle.
// Push writes the first free cell, pop shifts every cell down by one, and an
// unused opcode only reports status. For these the result appears in the
// cycle after acceptance and busy stays low, so one of them can be accepted
// in every cycle.
// Remove first clears the valid bit of every matching cell, then
// lets the remaining entries slide down one cell per cycle into the holes
// until the held entries are contiguous again. busy is high from the cycle
// after acceptance until the result is shown, which happens once no cell of
// the chain is a hole any more.
// The receiver cannot stall. Reset (synchronous, active low) empties the queue
// and clears all status; stored entry values are kept but never read while unused.
module fifo_queue_with_remove #(
    parameter int DEPTH = fqr_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [fqr_pkg::OP_W-1:0]      i_op,
    input  logic [fqr_pkg::DATA_W-1:0]    i_value_in,
    output logic                          busy,
    output logic                          o_valid,
    output logic                          o_ok,
    output logic [fqr_pkg::DATA_W-1:0]    o_value_out,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic                          o_empty_res,
    output logic                          o_full_res
);
    import fqr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SQUEEZE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_hit;
    logic              r_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_value_out;
    logic [CNT_W-1:0]  r_out_count;

    t_cell_cmd         cell_cmd;
    t_link             links [DEPTH+1];
    logic [DEPTH-1:0]  match_vec;
    logic [DEPTH-1:0]  hole_vec;
    logic [DEPTH-1:0]  valid_vec;
    logic              accept;
    logic              can_push;
    logic              can_pop;
    logic              squeeze_done;
    logic [CNT_W-1:0]  held_count;

    assign accept       = start && !busy;
    assign busy         = (r_state == S_SQUEEZE);
    assign can_push     = (r_count != FULL_CNT);
    assign can_pop      = (r_count != '0);
    assign squeeze_done = ~|hole_vec;

    // Nothing ever sits above the last cell.
    assign links[DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic below_valid;
            if (gi == 0) begin : g_first
                assign below_valid = 1'b1;
            end else begin : g_rest
                assign below_valid = links[gi-1].valid;
            end
            fqr_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (cell_cmd),
                .i_key         (i_value_in),
                .i_below_valid (below_valid),
                .i_above       (links[gi+1]),
                .o_link        (links[gi]),
                .o_match       (match_vec[gi]),
                .o_hole        (hole_vec[gi])
            );
            assign valid_vec[gi] = links[gi].valid;
        end
    endgenerate

    // Once the entries are contiguous, the count is the index just past the
    // last held cell. Only one cell can be that boundary, so the ORs combine.
    always_comb begin
        held_count = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (valid_vec[i] && !links[i+1].valid) begin
                held_count = held_count | CNT_W'(i + 1);
            end
        end
    end

    // Command to the cell chain.
    always_comb begin
        cell_cmd = CMD_HOLD;
        if (r_state == S_SQUEEZE) begin
            cell_cmd = CMD_SQUEEZE;
        end else if (accept) begin
            case (i_op)
                OP_PUSH:   cell_cmd = can_push ? CMD_PUSH : CMD_HOLD;
                OP_POP:    cell_cmd = can_pop ? CMD_POP : CMD_HOLD;
                OP_REMOVE: cell_cmd = CMD_MARK;
                default:   cell_cmd = CMD_HOLD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_valid     <= 1'b0;
            r_ok        <= 1'b0;
            r_value_out <= '0;
            r_out_count <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ok        <= 1'b0;
                        r_value_out <= '0;
                        r_out_count <= r_count;
                        case (i_op)
                            OP_PUSH: begin
                                r_valid <= 1'b1;
                                if (can_push) begin
                                    r_ok        <= 1'b1;
                                    r_count     <= r_count + 1'b1;
                                    r_out_count <= r_count + 1'b1;
                                end
                            end
                            OP_POP: begin
                                r_valid <= 1'b1;
                                if (can_pop) begin
                                    r_ok        <= 1'b1;
                                    r_value_out <= links[0].data;
                                    r_count     <= r_count - 1'b1;
                                    r_out_count <= r_count - 1'b1;
                                end
                            end
                            OP_REMOVE: begin
                                r_hit   <= |match_vec;
                                r_state <= S_SQUEEZE;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SQUEEZE: begin
                    if (squeeze_done) begin
                        r_valid     <= 1'b1;
                        r_ok        <= r_hit;
                        r_value_out <= '0;
                        r_count     <= held_count;
                        r_out_count <= held_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_ok        = r_ok;
    assign o_value_out = r_value_out;
    assign o_count     = r_out_count;
    assign o_empty_res = (r_out_count == '0);
    assign o_full_res  = (r_out_count == FULL_CNT);

    // A remove always takes the block busy in the next cycle.
    a_remove_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_REMOVE) |=> busy)
        else $error("remove accepted without entering compaction");

    // When idle the held entries form a contiguous run from cell 0.
    a_idle_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (hole_vec == '0))
        else $error("hole in the cell chain while idle");

    // When idle the tracked count agrees with the cells that hold entries.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (held_count == r_count))
        else $error("tracked count disagrees with valid cells");

    // No result is shown while compaction is still under way.
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !squeeze_done) |=> !o_valid)
        else $error("result shown during compaction");

endmodule

// ===== tb/fqr_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for fifo_queue_with_remove: keeps a shadow copy of the queue,
// predicts the status of every accepted transaction and checks each result.
// Depends on fqr_pkg for the opcodes and the data width.
module fqr_checker #(
    parameter int DEPTH = fqr_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [fqr_pkg::OP_W-1:0]      i_op,
    input  logic [fqr_pkg::DATA_W-1:0]    i_value_in,
    input  logic                          i_res_valid,
    input  logic                          i_res_ok,
    input  logic [fqr_pkg::DATA_W-1:0]    i_res_value,
    input  logic [CNT_W-1:0]              i_res_count,
    input  logic                          i_res_empty,
    input  logic                          i_res_full,
    output int                            o_fail_count,
    output int                            o_pending
);
    import fqr_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              full;
    } t_status;

    logic [DATA_W-1:0] shadow_q[$];
    t_status           due_q[$];
    int                fails = 0;

    // Applies one operation to the shadow queue and returns the status it reports.
    function automatic t_status apply_queue_op(input logic [OP_W-1:0] op,
                                               input logic [DATA_W-1:0] val);
        t_status           res;
        logic [DATA_W-1:0] kept[$];
        res = '0;
        case (op)
            OP_PUSH: begin
                if (shadow_q.size() < DEPTH) begin
                    shadow_q.push_back(val);
                    res.ok = 1'b1;
                end
            end
            OP_POP: begin
                if (shadow_q.size() > 0) begin
                    res.value = shadow_q.pop_front();
                    res.ok    = 1'b1;
                end
            end
            OP_REMOVE: begin
                foreach (shadow_q[i]) begin
                    if (shadow_q[i] == val) res.ok = 1'b1;
                    else kept.push_back(shadow_q[i]);
                end
                shadow_q = kept;
            end
            default: ;
        endcase
        res.count = CNT_W'(shadow_q.size());
        res.empty = (shadow_q.size() == 0);
        res.full  = (shadow_q.size() == DEPTH);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_status want;
        t_status got;
        if (i_rst_n) begin
            // The result of a transaction never shares an edge with its own
            // acceptance, so results are checked before new predictions go in.
            if (i_res_valid) begin
                got = {i_res_ok, i_res_value, i_res_count, i_res_empty, i_res_full};
                if (due_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected, got ok=%0d value=%h count=%0d",
                             $time, got.ok, got.value, got.count);
                end else begin
                    want = due_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (got.ok !== want.ok)
                            $display("%0t: ok expected %0d, actual %0d",
                                     $time, want.ok, got.ok);
                        if (got.value !== want.value)
                            $display("%0t: value_out expected %h, actual %h",
                                     $time, want.value, got.value);
                        if (got.count !== want.count)
                            $display("%0t: count expected %0d, actual %0d",
                                     $time, want.count, got.count);
                        if (got.empty !== want.empty)
                            $display("%0t: empty_res expected %0d, actual %0d",
                                     $time, want.empty, got.empty);
                        if (got.full !== want.full)
                            $display("%0t: full_res expected %0d, actual %0d",
                                     $time, want.full, got.full);
                    end
                end
            end
            if (i_start && !i_busy)
                due_q.push_back(apply_queue_op(i_op, i_value_in));
        end
        o_fail_count <= fails;
        o_pending    <= due_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for fifo_queue_with_remove: drives directed and random
// transactions, pairs the block with fqr_checker and prints the verdict.
// Depends on fqr_pkg, fqr_checker and the RTL of the block.
module tb;
    import fqr_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // The block decodes only three opcodes; the fourth must leave it alone.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1450;
    // The last stretch of the run is sent back to back, with no gaps.
    localparam int QUIET_TAIL   = 200;
    // Settling time at the end of the run, with a margin over the longest remove.
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int DRAIN_LIMIT   = 1000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic [OP_W-1:0]      i_op;
    logic [DATA_W-1:0]    i_value_in;
    logic                 busy;
    logic                 o_valid;
    logic                 o_ok;
    logic [DATA_W-1:0]    o_value_out;
    logic [CNT_W-1:0]     o_count;
    logic                 o_empty_res;
    logic                 o_full_res;

    int fail_count;
    int pending;
    int n_push   = 0;
    int n_pop    = 0;
    int n_remove = 0;
    int n_unused = 0;
    int n_pauses = 0;

    fifo_queue_with_remove #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_op        (i_op),
        .i_value_in  (i_value_in),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_ok        (o_ok),
        .o_value_out (o_value_out),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_full_res  (o_full_res)
    );

    fqr_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_op         (i_op),
        .i_value_in   (i_value_in),
        .i_res_valid  (o_valid),
        .i_res_ok     (o_ok),
        .i_res_value  (o_value_out),
        .i_res_count  (o_count),
        .i_res_empty  (o_empty_res),
        .i_res_full   (o_full_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. The slowest legal run is well under a tenth of this: every
    // transaction a full-depth remove plus the longest sender gap.
    initial begin
        #5000000;
        $display("%0t: timeout with %0d results outstanding", $time, pending);
        $display("FAILED: results differ");
        $finish;
    end

    // Offers one transaction from a falling edge and holds it until a rising
    // edge sees busy low. busy is read right at the edge, before the block
    // updates it, so this is exactly the acceptance condition. start is left
    // high on return so that back-to-back transactions need no extra edge.
    task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        start      = 1'b1;
        i_op       = op;
        i_value_in = val;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        case (op)
            OP_PUSH:   n_push++;
            OP_POP:    n_pop++;
            OP_REMOVE: n_remove++;
            default:   n_unused++;
        endcase
    endtask

    // Sender goes quiet; the payload is scrambled meanwhile, which the block
    // must ignore since start is low.
    task automatic idle_gap(input int cycles);
        start = 1'b0;
        repeat (cycles) begin
            i_op       = OP_W'($urandom);
            i_value_in = $urandom;
            @(negedge i_clk);
        end
    endtask

    // Holds off new work until every outstanding result has been checked.
    task automatic wait_drained();
        start = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        @(negedge i_clk);
        n_pauses++;
    endtask

    initial begin : stimulus
        logic [DATA_W-1:0] pool[8];
        int                pool_n;
        int                push_pct;
        int                phase_left;
        int                r;
        int                waited;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;

        start      = 1'b0;
        i_op       = OP_PUSH;
        i_value_in = '0;
        i_rst_n    = 1'b0;
        pool_n     = 1;
        push_pct   = 50;
        phase_left = 0;
        foreach (pool[j]) pool[j] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Refused operations on an empty queue come first,
        // including the unused opcode, which must report status only.
        issue_cmd(OP_POP, 32'hDEAD_BEEF);
        issue_cmd(OP_REMOVE, 32'h0000_0000);
        issue_cmd(OP_UNUSED, 32'hFFFF_FFFF);
        // A remove that deletes two non-adjacent copies of the all-ones word,
        // then a remove that finds nothing, then a pop back to empty.
        issue_cmd(OP_PUSH, 32'hFFFF_FFFF);
        issue_cmd(OP_PUSH, 32'h0000_0000);
        issue_cmd(OP_PUSH, 32'hFFFF_FFFF);
        issue_cmd(OP_REMOVE, 32'hFFFF_FFFF);
        issue_cmd(OP_REMOVE, 32'h0000_0005);
        issue_cmd(OP_POP, 32'h0000_0000);
        // Fill to the brim with every other cell holding the same word, try
        // one push too many, then remove that word, which leaves a hole
        // between every two kept entries.
        for (int k = 0; k < DEPTH; k++)
            issue_cmd(OP_PUSH, (k % 2) ? 32'hA5A5_A5A5 : DATA_W'(k));
        issue_cmd(OP_PUSH, 32'h1234_5678);
        issue_cmd(OP_REMOVE, 32'hA5A5_A5A5);
        wait_drained();

        // Random part. It runs in phases that lean toward pushing, popping or
        // a balance, so the fill level swings between empty and full. Values
        // mostly come from a small per-phase pool so that removes find
        // duplicates; the rest are arbitrary words and the two extremes.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(30, 80);
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 50;
                    default: push_pct = 25;
                endcase
                pool_n = $urandom_range(1, 8);
                foreach (pool[j]) pool[j] = (j % 2) ? $urandom : $urandom_range(0, 15);
            end
            phase_left--;

            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < push_pct)
                op = OP_PUSH;
            else if (r < push_pct + (100 - push_pct) / 2)
                op = OP_POP;
            else
                op = OP_REMOVE;

            r = $urandom_range(0, 99);
            if (r < 70)
                val = pool[$urandom_range(0, pool_n - 1)];
            else if (r < 95)
                val = $urandom;
            else
                val = r[0] ? '1 : '0;

            issue_cmd(op, val);

            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            else if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < 15)
                idle_gap($urandom_range(1, 9));
        end

        // Let the last results come in, then give the block time to show
        // anything it should not.
        start  = 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);

        $display("Sent %0d transactions: %0d push, %0d pop, %0d remove, %0d unused opcode.",
                 n_push + n_pop + n_remove + n_unused, n_push, n_pop, n_remove, n_unused);
        $display("Sender drained the queue %0d times; the final %0d went back to back.",
                 n_pauses, QUIET_TAIL);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
src/fqr_pkg.sv
src/fqr_cell.sv
src/fifo_queue_with_remove.sv
tb/fqr_checker.sv
tb/tb.sv
